### rtl/rtc_pkg.sv
// Package for the calendar RTC: time record type, access codes, register offsets
// and the month-length helpers. Depends on nothing.
`default_nettype none

package rtc_pkg;

  // Current calendar time, as held in the clock registers.
  typedef struct packed {
    logic [11:0] year;
    logic [3:0]  month;
    logic [4:0]  day;
    logic [2:0]  weekday;
    logic [4:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
  } rtc_time_t;

  // Request kinds.
  localparam logic [1:0] MODE_READ  = 2'd0;
  localparam logic [1:0] MODE_WRITE = 2'd1;
  localparam logic [1:0] MODE_TICK  = 2'd2;

  // Register byte offsets.
  localparam logic [7:0] OFS_CLKDIV = 8'h00;
  localparam logic [7:0] OFS_SETUP0 = 8'h04;
  localparam logic [7:0] OFS_SETUP1 = 8'h08;
  localparam logic [7:0] OFS_CTRL   = 8'h0C;
  localparam logic [7:0] OFS_ALARM0 = 8'h10;
  localparam logic [7:0] OFS_ALARM1 = 8'h14;
  localparam logic [7:0] OFS_DATE   = 8'h18;
  localparam logic [7:0] OFS_TIME   = 8'h1C;
  localparam logic [7:0] OFS_INTR   = 8'h20;
  localparam logic [7:0] OFS_INTE   = 8'h24;
  localparam logic [7:0] OFS_INTF   = 8'h28;
  localparam logic [7:0] OFS_INTS   = 8'h2C;

  // Bit positions in the CTRL and alarm words.
  localparam int CTRL_EN_BIT   = 0;
  localparam int CTRL_LOAD_BIT = 4;
  localparam int AL_YEAR_BIT   = 26;
  localparam int AL_MONTH_BIT  = 25;
  localparam int AL_DAY_BIT    = 24;
  localparam int AL_WDAY_BIT   = 31;
  localparam int AL_HOUR_BIT   = 30;
  localparam int AL_MIN_BIT    = 29;
  localparam int AL_SEC_BIT    = 28;

  // Number of multiples of 100 that fit in a 12-bit year.
  localparam int NumCenturies = 4096 / 100 + 1;

  // True when the year is a whole multiple of 100 (compare against each one).
  function automatic logic is_century(input logic [11:0] y);
    logic hit;
    hit = 1'b0;
    for (int k = 0; k < NumCenturies; k++) begin
      if (y == 12'(k * 100)) begin
        hit = 1'b1;
      end
    end
    return hit;
  endfunction

  // Gregorian leap year: divisible by 4, and centuries only when divisible by 400.
  // A century is divisible by 400 exactly when it is divisible by 16.
  function automatic logic is_leap(input logic [11:0] y);
    return (y[1:0] == 2'd0) && (!is_century(y) || (y[3:0] == 4'd0));
  endfunction

  // Days in a month; a month outside one to twelve counts as 31 days.
  function automatic logic [4:0] month_days(input logic [11:0] y, input logic [3:0] m);
    logic [4:0] d;
    case (m) inside
      4'd4, 4'd6, 4'd9, 4'd11: d = 5'd30;
      4'd2:                    d = is_leap(y) ? 5'd29 : 5'd28;
      default:                 d = 5'd31;
    endcase
    return d;
  endfunction

endpackage

`default_nettype wire

### rtl/rtc_if.sv
// Request and response channel interfaces of the calendar RTC.
// Plain valid/ready channels; depends on nothing.
`default_nettype none

interface rtc_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  mode;
  logic [7:0]  reg_offset;
  logic [31:0] write_data;

  modport source (output valid, mode, reg_offset, write_data, input ready);
  modport sink   (input valid, mode, reg_offset, write_data, output ready);
endinterface

interface rtc_rsp_if;
  logic        valid;
  logic        ready;
  logic [31:0] read_data;
  logic        irq_level;

  modport source (output valid, read_data, irq_level, input ready);
  modport sink   (input valid, read_data, irq_level, output ready);
endinterface

`default_nettype wire

### rtl/rtc_calendar.sv
// One-second advance of the calendar: seconds through years with leap years.
// Depends on rtc_pkg.
`default_nettype none

module rtc_calendar (
  input  rtc_pkg::rtc_time_t time_i,
  output rtc_pkg::rtc_time_t time_o
);
  import rtc_pkg::*;

  logic [6:0] sec_inc;
  logic [6:0] min_inc;
  logic [5:0] hour_inc;
  logic [3:0] wday_inc;
  logic [5:0] day_inc;
  logic [4:0] month_inc;
  logic [4:0] month_len;

  assign sec_inc   = {1'b0, time_i.second} + 7'd1;
  assign min_inc   = {1'b0, time_i.minute} + 7'd1;
  assign hour_inc  = {1'b0, time_i.hour} + 6'd1;
  assign wday_inc  = {1'b0, time_i.weekday} + 4'd1;
  assign day_inc   = {1'b0, time_i.day} + 6'd1;
  assign month_inc = {1'b0, time_i.month} + 5'd1;
  assign month_len = month_days(time_i.year, time_i.month);

  // Ripple the carry upward; out-of-range seconds, minutes and hours roll to zero, days and months to one.
  always_comb begin
    time_o = time_i;
    if (sec_inc < 7'd60) begin
      time_o.second = sec_inc[5:0];
    end else begin
      time_o.second = '0;
      if (min_inc < 7'd60) begin
        time_o.minute = min_inc[5:0];
      end else begin
        time_o.minute = '0;
        if (hour_inc < 6'd24) begin
          time_o.hour = hour_inc[4:0];
        end else begin
          time_o.hour = '0;
          // Weekday advances modulo seven.
          time_o.weekday = (wday_inc >= 4'd7) ? 3'(wday_inc - 4'd7) : wday_inc[2:0];
          if (day_inc <= {1'b0, month_len}) begin
            time_o.day = day_inc[4:0];
          end else begin
            time_o.day = 5'd1;
            if (month_inc <= 5'd12) begin
              time_o.month = month_inc[3:0];
            end else begin
              time_o.month = 4'd1;
              time_o.year  = time_i.year + 12'd1;
            end
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

### rtl/rtc_alarm.sv
// Alarm compare: matches the time against the alarm words on the enabled fields.
// Depends on rtc_pkg.
`default_nettype none

module rtc_alarm (
  input  logic [31:0]        alarm_date_i,
  input  logic [31:0]        alarm_time_i,
  input  rtc_pkg::rtc_time_t time_i,
  output logic               match_o
);
  import rtc_pkg::*;

  logic armed;
  logic fields_ok;

  // The alarm is armed when at least one match bit is set.
  assign armed = alarm_date_i[AL_YEAR_BIT] | alarm_date_i[AL_MONTH_BIT] |
                 alarm_date_i[AL_DAY_BIT]  | alarm_time_i[AL_WDAY_BIT]  |
                 alarm_time_i[AL_HOUR_BIT] | alarm_time_i[AL_MIN_BIT]   |
                 alarm_time_i[AL_SEC_BIT];

  // Each enabled field must equal the current value.
  assign fields_ok =
      (!alarm_date_i[AL_YEAR_BIT]  || (alarm_date_i[23:12] == time_i.year))    &&
      (!alarm_date_i[AL_MONTH_BIT] || (alarm_date_i[11:8]  == time_i.month))   &&
      (!alarm_date_i[AL_DAY_BIT]   || (alarm_date_i[4:0]   == time_i.day))     &&
      (!alarm_time_i[AL_WDAY_BIT]  || (alarm_time_i[26:24] == time_i.weekday)) &&
      (!alarm_time_i[AL_HOUR_BIT]  || (alarm_time_i[20:16] == time_i.hour))    &&
      (!alarm_time_i[AL_MIN_BIT]   || (alarm_time_i[13:8]  == time_i.minute))  &&
      (!alarm_time_i[AL_SEC_BIT]   || (alarm_time_i[5:0]   == time_i.second));

  assign match_o = armed & fields_ok;

endmodule

`default_nettype wire

### rtl/calendar_rtc_with_alarm.sv
// Calendar RTC with alarm. A request is registered, processed in one pass, and its
// response is registered: an accepted request passes through the request register and then
// the response register, which holds the response until the sink takes it.
// Throughput is one request per cycle while the response side takes results; the
// calendar carry chain and alarm compare sit between the request and response registers.
// Reset (asynchronous, active low) clears both valid flags, the register bank, the calendar
// and the interrupts; the request and response payload registers are not reset.
// Depends on rtc_pkg, rtc_if, rtc_calendar and rtc_alarm.
`default_nettype none

module calendar_rtc_with_alarm (
  input  logic       clk_i,
  input  logic       rst_ni,
  rtc_req_if.sink    req_i,
  rtc_rsp_if.source  rsp_o
);
  import rtc_pkg::*;

  // Request register.
  logic        in_valid_q, in_valid_d;
  logic [1:0]  in_mode_q;
  logic [7:0]  in_ofs_q;
  logic [31:0] in_data_q;

  // Response register.
  logic        out_valid_q, out_valid_d;
  logic [31:0] out_rdata_q, out_rdata_d;
  logic        out_irq_q, out_irq_d;

  // Block state.
  logic [31:0] div_limit_q, div_limit_d;
  logic [31:0] div_count_q, div_count_d;
  logic [31:0] setup_date_q, setup_date_d;
  logic [31:0] setup_time_q, setup_time_d;
  logic [31:0] alarm_date_q, alarm_date_d;
  logic [31:0] alarm_time_q, alarm_time_d;
  logic        clk_en_q, clk_en_d;
  rtc_time_t   time_q, time_d, time_inc;
  logic        raw_irq_q, raw_irq_d, raw_irq_pre;
  logic        irq_en_q, irq_en_d;
  logic        irq_force_q, irq_force_d;
  logic        was_match_q, was_match_d;

  logic        req_accept;
  logic        advance;
  logic        eval_en;
  logic        match;

  // Handshake: the request stage moves on when the response register is free.
  assign advance    = in_valid_q & (~out_valid_q | rsp_o.ready);
  assign req_i.ready = ~in_valid_q | advance;
  assign req_accept = req_i.valid & req_i.ready;

  assign in_valid_d  = req_accept ? 1'b1 : (advance ? 1'b0 : in_valid_q);
  assign out_valid_d = advance ? 1'b1 : ((out_valid_q & rsp_o.ready) ? 1'b0 : out_valid_q);

  assign rsp_o.valid     = out_valid_q;
  assign rsp_o.read_data = out_rdata_q;
  assign rsp_o.irq_level = out_irq_q;

  rtc_calendar u_calendar (
    .time_i (time_q),
    .time_o (time_inc)
  );

  rtc_alarm u_alarm (
    .alarm_date_i (alarm_date_d),
    .alarm_time_i (alarm_time_d),
    .time_i       (time_d),
    .match_o      (match)
  );

  // Register writes and ticks.
  always_comb begin
    div_limit_d  = div_limit_q;
    div_count_d  = div_count_q;
    setup_date_d = setup_date_q;
    setup_time_d = setup_time_q;
    alarm_date_d = alarm_date_q;
    alarm_time_d = alarm_time_q;
    clk_en_d     = clk_en_q;
    time_d       = time_q;
    raw_irq_pre  = raw_irq_q;
    irq_en_d     = irq_en_q;
    irq_force_d  = irq_force_q;
    eval_en      = 1'b0;
    case (in_mode_q)
      MODE_WRITE: begin
        eval_en = 1'b1;
        case (in_ofs_q)
          OFS_CLKDIV: div_limit_d  = in_data_q;
          OFS_SETUP0: setup_date_d = in_data_q;
          OFS_SETUP1: setup_time_d = in_data_q;
          OFS_CTRL: begin
            clk_en_d = in_data_q[CTRL_EN_BIT];
            if (in_data_q[CTRL_LOAD_BIT]) begin
              time_d.year    = setup_date_q[23:12];
              time_d.month   = setup_date_q[11:8];
              time_d.day     = setup_date_q[4:0];
              time_d.weekday = setup_time_q[26:24];
              time_d.hour    = setup_time_q[20:16];
              time_d.minute  = setup_time_q[13:8];
              time_d.second  = setup_time_q[5:0];
              div_count_d    = '0;
            end
          end
          OFS_ALARM0: begin
            alarm_date_d = in_data_q;
            raw_irq_pre  = 1'b0;
          end
          OFS_ALARM1: begin
            alarm_time_d = in_data_q;
            raw_irq_pre  = 1'b0;
          end
          OFS_INTR: begin
            if (in_data_q[0]) begin
              raw_irq_pre = 1'b0;
            end
          end
          OFS_INTE: irq_en_d    = in_data_q[0];
          OFS_INTF: irq_force_d = in_data_q[0];
          default: ;
        endcase
      end
      MODE_TICK: begin
        if (clk_en_q) begin
          // Divided tick once the count reaches the limit.
          if (div_count_q >= div_limit_q) begin
            div_count_d = '0;
            time_d      = time_inc;
            eval_en     = 1'b1;
          end else begin
            div_count_d = div_count_q + 32'd1;
          end
        end
      end
      default: ;
    endcase
  end

  // Alarm edge detect on the updated state.
  assign raw_irq_d   = raw_irq_pre | (eval_en & match & ~was_match_q);
  assign was_match_d = eval_en ? match : was_match_q;

  // Read data from the state before the request, and the interrupt line after it.
  always_comb begin
    out_rdata_d = '0;
    if (in_mode_q == MODE_READ) begin
      case (in_ofs_q)
        OFS_CLKDIV: out_rdata_d = div_limit_q;
        OFS_SETUP0: out_rdata_d = setup_date_q;
        OFS_SETUP1: out_rdata_d = setup_time_q;
        OFS_CTRL:   out_rdata_d = {30'd0, clk_en_q, clk_en_q};
        OFS_ALARM0: out_rdata_d = alarm_date_q;
        OFS_ALARM1: out_rdata_d = alarm_time_q;
        OFS_DATE:   out_rdata_d = {8'd0, time_q.year, time_q.month, 3'd0, time_q.day};
        OFS_TIME:   out_rdata_d = {5'd0, time_q.weekday, 3'd0, time_q.hour,
                                   2'd0, time_q.minute, 2'd0, time_q.second};
        OFS_INTR:   out_rdata_d = {31'd0, raw_irq_q};
        OFS_INTE:   out_rdata_d = {31'd0, irq_en_q};
        OFS_INTF:   out_rdata_d = {31'd0, irq_force_q};
        OFS_INTS:   out_rdata_d = {31'd0, (raw_irq_q | irq_force_q) & irq_en_q};
        default:    out_rdata_d = '0;
      endcase
    end
  end

  assign out_irq_d = (raw_irq_d | irq_force_d) & irq_en_d;

  // Handshake registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Request and response payload.
  always_ff @(posedge clk_i) begin
    if (req_accept) begin
      in_mode_q <= req_i.mode;
      in_ofs_q  <= req_i.reg_offset;
      in_data_q <= req_i.write_data;
    end
    if (advance) begin
      out_rdata_q <= out_rdata_d;
      out_irq_q   <= out_irq_d;
    end
  end

  // Block state, updated once per processed request.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      div_limit_q  <= '0;
      div_count_q  <= '0;
      setup_date_q <= '0;
      setup_time_q <= '0;
      alarm_date_q <= '0;
      alarm_time_q <= '0;
      clk_en_q     <= 1'b0;
      time_q       <= '0;
      raw_irq_q    <= 1'b0;
      irq_en_q     <= 1'b0;
      irq_force_q  <= 1'b0;
      was_match_q  <= 1'b0;
    end else if (advance) begin
      div_limit_q  <= div_limit_d;
      div_count_q  <= div_count_d;
      setup_date_q <= setup_date_d;
      setup_time_q <= setup_time_d;
      alarm_date_q <= alarm_date_d;
      alarm_time_q <= alarm_time_d;
      clk_en_q     <= clk_en_d;
      time_q       <= time_d;
      raw_irq_q    <= raw_irq_d;
      irq_en_q     <= irq_en_d;
      irq_force_q  <= irq_force_d;
      was_match_q  <= was_match_d;
    end
  end

endmodule

`default_nettype wire

### rtl/rtc_chk.sv
// Port-level checker for the calendar RTC, bound to the top level.
// Depends on the top level's request and response channels.
`default_nettype none

module rtc_chk (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        req_valid_i,
  input logic        req_ready_i,
  input logic        rsp_valid_i,
  input logic        rsp_ready_i,
  input logic [31:0] rsp_read_data_i,
  input logic        rsp_irq_level_i
);

  logic [2:0] pending_q;
  logic       req_fire;
  logic       rsp_fire;

  assign req_fire = req_valid_i & req_ready_i;
  assign rsp_fire = rsp_valid_i & rsp_ready_i;

  // Requests accepted but not yet answered.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pending_q <= '0;
    end else begin
      pending_q <= pending_q + 3'(req_fire) - 3'(rsp_fire);
    end
  end

  // A stalled response stays valid.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> rsp_valid_i)
    else $error("response dropped while stalled");

  // A stalled response keeps its payload.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i && !rsp_ready_i |=> $stable(rsp_read_data_i) && $stable(rsp_irq_level_i))
    else $error("response payload changed while stalled");

  // The request and response registers hold at most two requests.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= 3'd2)
    else $error("more requests in flight than pipeline stages");

  // Every response belongs to an accepted request.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    rsp_valid_i |-> pending_q != 3'd0)
    else $error("response without a pending request");

endmodule

bind calendar_rtc_with_alarm rtc_chk u_rtc_chk (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .req_valid_i     (req_i.valid),
  .req_ready_i     (req_i.ready),
  .rsp_valid_i     (rsp_o.valid),
  .rsp_ready_i     (rsp_o.ready),
  .rsp_read_data_i (rsp_o.read_data),
  .rsp_irq_level_i (rsp_o.irq_level)
);

`default_nettype wire

### tb/tb_calendar_rtc_with_alarm.sv
// Testbench for calendar_rtc_with_alarm: drives register reads, writes and clock ticks, and
// checks every response against a cycle-free model of the calendar, alarm and interrupts.
// Depends on rtc_pkg, rtc_if (rtc_req_if, rtc_rsp_if) and the calendar_rtc_with_alarm RTL.

module tb_calendar_rtc_with_alarm;
  import rtc_pkg::*;

  localparam int ItemTarget = 1750;
  localparam int StallLimit = 1000;
  localparam logic [1:0]  MODE_NOP  = 2'd3;
  localparam logic [31:0] CTRL_RUN  = 32'd1 << CTRL_EN_BIT;
  localparam logic [31:0] CTRL_LOAD = 32'd1 << CTRL_LOAD_BIT;

  typedef struct {
    logic [31:0] read_data;
    logic        irq_level;
  } rtc_reply_t;

  // Untimed copy of the register bank and calendar; it owes one reply per request.
  class rtc_mirror;
    logic [31:0] div_limit = '0;
    logic [31:0] div_count = '0;
    logic [31:0] setup_date = '0;
    logic [31:0] setup_time = '0;
    logic [31:0] alarm_date = '0;
    logic [31:0] alarm_time = '0;
    logic        enabled = 1'b0;
    logic        raw_irq = 1'b0;
    logic        irq_en = 1'b0;
    logic        irq_frc = 1'b0;
    logic        matched_q = 1'b0;
    rtc_time_t   now_t = '0;
    rtc_reply_t  owed[$];
    int          mismatches = 0;
    int          requests = 0;
    int          seconds_advanced = 0;
    int          alarms_raised = 0;

    // Days in a month; anything outside one to twelve counts as a long month.
    function int days_in(logic [11:0] y, logic [3:0] m);
      bit leap;
      leap = (y % 4 == 0) && ((y % 100 != 0) || (y % 400 == 0));
      if (m < 1 || m > 12) return 31;
      if (m == 2) return leap ? 29 : 28;
      if (m == 4 || m == 6 || m == 9 || m == 11) return 30;
      return 31;
    endfunction

    // One second of calendar time, with carries all the way up to the year.
    function void step_one_second();
      seconds_advanced++;
      if (int'(now_t.second) + 1 < 60) begin
        now_t.second = now_t.second + 6'd1;
        return;
      end
      now_t.second = '0;
      if (int'(now_t.minute) + 1 < 60) begin
        now_t.minute = now_t.minute + 6'd1;
        return;
      end
      now_t.minute = '0;
      if (int'(now_t.hour) + 1 < 24) begin
        now_t.hour = now_t.hour + 5'd1;
        return;
      end
      now_t.hour = '0;
      now_t.weekday = 3'((int'(now_t.weekday) + 1) % 7);
      if (int'(now_t.day) + 1 <= days_in(now_t.year, now_t.month)) begin
        now_t.day = now_t.day + 5'd1;
        return;
      end
      now_t.day = 5'd1;
      if (int'(now_t.month) + 1 <= 12) begin
        now_t.month = now_t.month + 4'd1;
        return;
      end
      now_t.month = 4'd1;
      now_t.year = now_t.year + 12'd1;
    endfunction

    // The alarm fires on a rising edge of the masked compare.
    function void update_alarm();
      bit armed;
      bit hit;
      armed = alarm_date[AL_YEAR_BIT] || alarm_date[AL_MONTH_BIT] || alarm_date[AL_DAY_BIT] ||
              alarm_time[AL_WDAY_BIT] || alarm_time[AL_HOUR_BIT] || alarm_time[AL_MIN_BIT] ||
              alarm_time[AL_SEC_BIT];
      hit = 1'b1;
      if (alarm_date[AL_YEAR_BIT] && alarm_date[23:12] != now_t.year) hit = 1'b0;
      if (alarm_date[AL_MONTH_BIT] && alarm_date[11:8] != now_t.month) hit = 1'b0;
      if (alarm_date[AL_DAY_BIT] && alarm_date[4:0] != now_t.day) hit = 1'b0;
      if (alarm_time[AL_WDAY_BIT] && alarm_time[26:24] != now_t.weekday) hit = 1'b0;
      if (alarm_time[AL_HOUR_BIT] && alarm_time[20:16] != now_t.hour) hit = 1'b0;
      if (alarm_time[AL_MIN_BIT] && alarm_time[13:8] != now_t.minute) hit = 1'b0;
      if (alarm_time[AL_SEC_BIT] && alarm_time[5:0] != now_t.second) hit = 1'b0;
      if (armed && hit && !matched_q) begin
        raw_irq = 1'b1;
        alarms_raised++;
      end
      matched_q = armed && hit;
    endfunction

    function logic irq_line();
      return (raw_irq | irq_frc) & irq_en;
    endfunction

    function logic [31:0] read_reg(logic [7:0] ofs);
      case (ofs)
        OFS_CLKDIV: return div_limit;
        OFS_SETUP0: return setup_date;
        OFS_SETUP1: return setup_time;
        OFS_CTRL:   return enabled ? 32'd3 : 32'd0;
        OFS_ALARM0: return alarm_date;
        OFS_ALARM1: return alarm_time;
        OFS_DATE:   return {8'd0, now_t.year, now_t.month, 3'd0, now_t.day};
        OFS_TIME:   return {5'd0, now_t.weekday, 3'd0, now_t.hour, 2'd0, now_t.minute,
                            2'd0, now_t.second};
        OFS_INTR:   return {31'd0, raw_irq};
        OFS_INTE:   return {31'd0, irq_en};
        OFS_INTF:   return {31'd0, irq_frc};
        OFS_INTS:   return {31'd0, irq_line()};
        default:    return 32'd0;
      endcase
    endfunction

    // Every write, even to an unused offset, re-runs the alarm compare.
    function void write_reg(logic [7:0] ofs, logic [31:0] v);
      case (ofs)
        OFS_CLKDIV: div_limit = v;
        OFS_SETUP0: setup_date = v;
        OFS_SETUP1: setup_time = v;
        OFS_CTRL: begin
          enabled = v[CTRL_EN_BIT];
          if (v[CTRL_LOAD_BIT]) begin
            now_t.year    = setup_date[23:12];
            now_t.month   = setup_date[11:8];
            now_t.day     = setup_date[4:0];
            now_t.weekday = setup_time[26:24];
            now_t.hour    = setup_time[20:16];
            now_t.minute  = setup_time[13:8];
            now_t.second  = setup_time[5:0];
            div_count     = '0;
          end
        end
        OFS_ALARM0: begin
          alarm_date = v;
          raw_irq = 1'b0;
        end
        OFS_ALARM1: begin
          alarm_time = v;
          raw_irq = 1'b0;
        end
        OFS_INTR: begin
          if (v[0]) raw_irq = 1'b0;
        end
        OFS_INTE: irq_en = v[0];
        OFS_INTF: irq_frc = v[0];
        default: ;
      endcase
      update_alarm();
    endfunction

    // Applies one accepted request and queues the reply it owes.
    function void log_request(logic [1:0] mode, logic [7:0] ofs, logic [31:0] data);
      rtc_reply_t r;
      r.read_data = '0;
      requests++;
      case (mode)
        MODE_READ:  r.read_data = read_reg(ofs);
        MODE_WRITE: write_reg(ofs, data);
        MODE_TICK: begin
          if (enabled) begin
            if ({1'b0, div_count} + 33'd1 > {1'b0, div_limit}) begin
              div_count = '0;
              step_one_second();
              update_alarm();
            end else begin
              div_count = div_count + 32'd1;
            end
          end
        end
        default: ;
      endcase
      r.irq_level = irq_line();
      owed.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (mismatches < 40) begin
        $display("mismatch on %s at reply %0d: got %h, want %h", what, requests, got, want);
      end
      mismatches++;
    endtask

    task compare_response(logic [31:0] rd, logic irq);
      rtc_reply_t w;
      if (owed.size() == 0) begin
        report("reply with no request outstanding", rd, 32'd0);
        return;
      end
      w = owed.pop_front();
      if (rd !== w.read_data) report("read_data", rd, w.read_data);
      if (irq !== w.irq_level) report("irq_level", {31'd0, irq}, {31'd0, w.irq_level});
    endtask
  endclass

  logic clk_i = 1'b0;
  logic rst_ni;
  int   issued = 0;
  int   gap_pct = 0;
  int   stall_pct = 0;
  bit   calm = 1'b0;
  int   quiet_cycles = 0;
  rtc_mirror mirror = new();

  rtc_req_if req_ch();
  rtc_rsp_if rsp_ch();

  calendar_rtc_with_alarm i_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req_ch),
    .rsp_o  (rsp_ch)
  );

  always #10 clk_i = ~clk_i;

  // Monitor both channels and watch for a hang.
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      mirror.compare_response(rsp_ch.read_data, rsp_ch.irq_level);
    end
    if (rst_ni && req_ch.valid && req_ch.ready) begin
      mirror.log_request(req_ch.mode, req_ch.reg_offset, req_ch.write_data);
    end
    if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("watchdog: nothing moved for %0d cycles", StallLimit);
      $display("status: fail");
      $finish;
    end
  end

  // Response side takes replies, with random stall bursts until the final stretch.
  initial begin
    rsp_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (!calm && $urandom_range(0, 99) < stall_pct) begin
        rsp_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      rsp_ch.ready <= 1'b1;
    end
  end

  function automatic logic [31:0] date_word(logic [11:0] y, logic [3:0] m, logic [4:0] d);
    return {8'd0, y, m, 3'd0, d};
  endfunction

  function automatic logic [31:0] time_word(logic [2:0] wd, logic [4:0] h, logic [5:0] mi,
                                            logic [5:0] s);
    return {5'd0, wd, 3'd0, h, 2'd0, mi, 2'd0, s};
  endfunction

  // Present one request, optionally after an idle burst, and wait until it is taken.
  task automatic send(input logic [1:0] mode, input logic [7:0] ofs, input logic [31:0] data);
    if (!calm && $urandom_range(0, 99) < gap_pct) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    req_ch.valid      <= 1'b1;
    req_ch.mode       <= mode;
    req_ch.reg_offset <= ofs;
    req_ch.write_data <= data;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    issued++;
  endtask

  function automatic logic [7:0] any_register();
    return 8'(4 * $urandom_range(0, 11));
  endfunction

  // Load a time, usually close to a rollover, arm an alarm a few seconds ahead and tick to it.
  task automatic run_session();
    logic [11:0] yr;
    logic [3:0]  mo;
    logic [4:0]  dy;
    logic [2:0]  wd;
    logic [4:0]  hr;
    logic [5:0]  mi;
    logic [5:0]  sc;
    logic [31:0] div;
    logic [31:0] dword;
    logic [31:0] tword;
    logic [31:0] ad;
    logic [31:0] at;
    logic [31:0] ctrl;
    int          lead;
    int          span;
    case ($urandom_range(0, 5))
      0:       yr = 12'd2000;
      1:       yr = 12'd1900;
      2:       yr = 12'd4095;
      3:       yr = 12'(4 * $urandom_range(0, 1023));
      default: yr = 12'($urandom);
    endcase
    mo = ($urandom_range(0, 7) == 0) ? 4'($urandom) : 4'($urandom_range(1, 12));
    if ($urandom_range(0, 2) == 0) begin
      dy = 5'($urandom);
    end else begin
      dy = 5'(mirror.days_in(yr, mo) - $urandom_range(0, 1));
    end
    wd = 3'($urandom);
    hr = ($urandom_range(0, 3) == 0) ? 5'($urandom) : 5'd23;
    mi = ($urandom_range(0, 3) == 0) ? 6'($urandom) : 6'd59;
    sc = ($urandom_range(0, 5) == 0) ? 6'($urandom) : 6'($urandom_range(40, 59));
    lead = $urandom_range(1, 20);
    div = ($urandom_range(0, 9) == 0) ? 32'($urandom_range(3, 7)) : 32'($urandom_range(0, 2));

    // Unused bits of the setup and alarm words carry random data; match bits are random.
    dword = $urandom;
    dword[23:12] = yr;
    dword[11:8] = mo;
    dword[4:0] = dy;
    tword = $urandom;
    tword[26:24] = wd;
    tword[20:16] = hr;
    tword[13:8] = mi;
    tword[5:0] = sc;
    ad = dword ^ (32'($urandom) & 32'hFF00_00E0);
    at = $urandom;
    at[26:24] = wd;
    at[20:16] = hr;
    at[13:8] = mi;
    at[5:0] = 6'((int'(sc) + lead) % 64);
    ctrl = $urandom | CTRL_LOAD;
    ctrl[CTRL_EN_BIT] = ($urandom_range(0, 9) != 0);

    send(MODE_WRITE, OFS_SETUP0, dword);
    send(MODE_WRITE, OFS_SETUP1, tword);
    send(MODE_WRITE, OFS_CLKDIV, div);
    send(MODE_WRITE, OFS_ALARM0, ad);
    send(MODE_WRITE, OFS_ALARM1, at);
    send(MODE_WRITE, OFS_INTE, {31'($urandom), ($urandom_range(0, 4) != 0)});
    send(MODE_WRITE, OFS_CTRL, ctrl);

    span = (lead + 1) * (int'(div) + 1) + $urandom_range(0, 8);
    repeat (span) begin
      if ($urandom_range(0, 5) == 0) begin
        send(MODE_READ, any_register(), $urandom);
      end else begin
        send(MODE_TICK, 8'($urandom), $urandom);
      end
    end
    send(MODE_READ, OFS_INTS, $urandom);
    send(MODE_READ, OFS_INTR, $urandom);
    if ($urandom_range(0, 1) == 0) send(MODE_WRITE, OFS_INTR, $urandom);
  endtask

  // Arbitrary requests of every kind, including unused and unaligned offsets.
  task automatic run_noise();
    repeat ($urandom_range(1, 6)) begin
      send(2'($urandom_range(0, 3)),
           ($urandom_range(0, 1) == 0) ? 8'($urandom) : any_register(), $urandom);
    end
  endtask

  task automatic run_sweep();
    for (int k = 0; k < 12; k++) send(MODE_READ, 8'(4 * k), $urandom);
  endtask

  initial begin
    rst_ni            <= 1'b0;
    req_ch.valid      <= 1'b0;
    req_ch.mode       <= MODE_READ;
    req_ch.reg_offset <= '0;
    req_ch.write_data <= '0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part: reset values, mode three, a disabled tick and the widest divider.
    send(MODE_READ, OFS_CTRL, '0);
    send(MODE_NOP, 8'hFF, '1);
    send(MODE_TICK, OFS_CTRL, '0);
    send(MODE_WRITE, OFS_CLKDIV, '1);
    send(MODE_WRITE, OFS_CTRL, CTRL_RUN);
    send(MODE_TICK, '0, '0);
    send(MODE_READ, OFS_CLKDIV, '0);
    send(MODE_WRITE, OFS_CLKDIV, '0);

    // End of year 4095 on weekday seven: everything rolls over and the year wraps to zero.
    send(MODE_WRITE, OFS_SETUP0, date_word(12'd4095, 4'd12, 5'd31));
    send(MODE_WRITE, OFS_SETUP1, time_word(3'd7, 5'd23, 6'd59, 6'd59));
    send(MODE_WRITE, OFS_INTE, 32'd1);
    send(MODE_WRITE, OFS_ALARM0, 32'd1 << AL_YEAR_BIT);
    send(MODE_WRITE, OFS_CTRL, CTRL_RUN | CTRL_LOAD);
    send(MODE_TICK, '0, '0);
    send(MODE_READ, OFS_DATE, '0);
    send(MODE_READ, OFS_TIME, '0);

    // Clearing, re-arming on seconds, then no match bits and the force bit.
    send(MODE_WRITE, OFS_INTR, 32'd1);
    send(MODE_WRITE, OFS_ALARM1, (32'd1 << AL_SEC_BIT) | 32'd1);
    send(MODE_TICK, '0, '0);
    send(MODE_WRITE, OFS_ALARM0, '0);
    send(MODE_WRITE, OFS_ALARM1, '0);
    send(MODE_WRITE, OFS_INTF, 32'd1);
    send(MODE_READ, OFS_INTS, '0);
    send(MODE_WRITE, OFS_INTF, '0);

    // Unaligned and unused offsets.
    send(MODE_READ, 8'h05, '0);
    send(MODE_WRITE, 8'h31, '1);
    send(MODE_READ, 8'h30, '0);

    // Random part: mostly load-arm-tick sessions, with noise and register sweeps.
    while (issued < ItemTarget) begin
      if (issued > ItemTarget * 17 / 20) calm = 1'b1;
      gap_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 30);
      stall_pct = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(2, 30);
      case ($urandom_range(0, 19))
        0, 1, 2, 3, 4:  run_noise();
        5, 6, 7:        run_sweep();
        default:        run_session();
      endcase
    end
    req_ch.valid <= 1'b0;

    @(posedge clk_i);
    while (mirror.owed.size() != 0) @(posedge clk_i);
    repeat (6) @(posedge clk_i);

    $display("covered %0d requests; the calendar advanced %0d seconds",
             mirror.requests, mirror.seconds_advanced);
    $display("the alarm fired %0d times and %0d mismatches were found",
             mirror.alarms_raised, mirror.mismatches);
    if (mirror.mismatches == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
